@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the encoder modules.
// Every check is sampled on the rising edge of i_clk and is switched off
// while the synchronous reset is held low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every active clock edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A property whose consequent is checked in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (prop)) else $error(msg);

`endif

@@ hw/rtl/dvs2of7_pkg.sv @@
`timescale 1ns / 1ps

package dvs2of7_pkg;

    // One event as it arrives.
    typedef struct packed {
        logic [6:0] pos_x;
        logic [6:0] pos_y;
        logic       polarity;
    } t_event;

    // One link symbol as it leaves.
    typedef struct packed {
        logic [6:0] symbol;
        logic [6:0] wire_level;
        logic       last;
    } t_symbol;

    // A classified event waiting to be sent.
    typedef struct packed {
        logic        parity;
        logic [31:0] key;
    } t_pkt;

    // Resolution modes.
    localparam logic [1:0] RES_128 = 2'd0;
    localparam logic [1:0] RES_64  = 2'd1;
    localparam logic [1:0] RES_32  = 2'd2;
    localparam logic [1:0] RES_16  = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_RES_MODE  = 1'b0;
    localparam logic REG_CHIP_ADDR = 1'b1;

    localparam logic [1:0]  RES_MODE_RESET  = 2'd0;
    localparam logic [15:0] CHIP_ADDR_RESET = 16'h0200;

    localparam logic [6:0] EOP_SYMBOL = 7'h60;

    // 2-of-7 code of a data nibble.
    function automatic logic [6:0] nibble_code(input logic [3:0] nib);
        logic [6:0] code;
        unique case (nib)
            4'h0: code = 7'h11;
            4'h1: code = 7'h12;
            4'h2: code = 7'h14;
            4'h3: code = 7'h18;
            4'h4: code = 7'h21;
            4'h5: code = 7'h22;
            4'h6: code = 7'h24;
            4'h7: code = 7'h28;
            4'h8: code = 7'h41;
            4'h9: code = 7'h42;
            4'hA: code = 7'h44;
            4'hB: code = 7'h48;
            4'hC: code = 7'h03;
            4'hD: code = 7'h06;
            4'hE: code = 7'h0C;
            default: code = 7'h09;
        endcase
        return code;
    endfunction

endpackage

@@ hw/rtl/dvs_event_2of7_packet_encoder_unit.sv @@
`timescale 1ns / 1ps

// Event-camera packet encoder for a 2-of-7 NRZ link. Each accepted event
// (pos_x, pos_y, polarity) becomes eleven output transactions: a parity header
// symbol, a zero header symbol, the eight nibbles of the 32-bit routing key
// (chip address above, packed event word below) least significant first, and
// the end-of-packet symbol, which alone carries last. Every output also gives
// the seven wire levels after that symbol toggled them; the levels carry over
// between packets and only reset clears them. The block sends one symbol per
// cycle on a single output register while the receiver does not stall it.
// Input and output are decoupled by a small event queue (QUEUE_DEPTH
// entries), so events are accepted while a packet is still being sent and
// the input stalls only when the queue is full. Configuration is written
// through the APB port at byte address 0 (resolution mode) and 4 (chip
// address), and should only be changed while no event is in flight; it
// takes effect for events accepted after the write.

module dvs_event_2of7_packet_encoder_unit import dvs2of7_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_event      i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_symbol     o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  r_res_mode;
    logic [15:0] r_chip_addr;
    logic        reg_idx;
    logic        cfg_wr;

    // Registers sit on word boundaries, so bit 2 of the address picks one.
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_mode  <= RES_MODE_RESET;
            r_chip_addr <= CHIP_ADDR_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RES_MODE:  r_res_mode  <= pwdata[1:0];
                REG_CHIP_ADDR: r_chip_addr <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RES_MODE:  prdata = {30'd0, r_res_mode};
            REG_CHIP_ADDR: prdata = {16'd0, r_chip_addr};
            default:       prdata = '0;
        endcase
    end

    // Front: pack and classify each event into a routing key and its parity.
    logic q_full, q_push, q_pop, q_valid;
    t_pkt front_pkt, q_pkt;

    dvs2of7_front u_front (
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_res_mode  (r_res_mode),
        .i_chip_addr (r_chip_addr),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (q_push),
        .o_pkt       (front_pkt)
    );

    // Queue of classified events between the two halves.
    dvs2of7_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pkt   (front_pkt),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_pkt   (q_pkt)
    );

    // Back: the symbol sequencer and the wire-level register.
    dvs2of7_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_pkt       (q_pkt),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

@@ hw/rtl/dvs2of7_front.sv @@
`timescale 1ns / 1ps

module dvs2of7_front import dvs2of7_pkg::*; (
    input  logic        i_in_valid,
    input  t_event      i_in,
    input  logic [1:0]  i_res_mode,
    input  logic [15:0] i_chip_addr,
    input  logic        i_q_full,
    output logic        o_in_stall,
    output logic        o_push,
    output t_pkt        o_pkt
);

    logic [15:0] ev_word;
    logic [31:0] key;

    always_comb begin
        ev_word = {1'b1, i_in.polarity, 14'd0};
        unique case (i_res_mode)
            RES_64:  ev_word[11:0] = {i_in.pos_y[6:1], i_in.pos_x[6:1]};
            RES_32:  ev_word[9:0]  = {i_in.pos_y[6:2], i_in.pos_x[6:2]};
            RES_16:  ev_word[7:0]  = {i_in.pos_y[6:3], i_in.pos_x[6:3]};
            default: ev_word[13:0] = {i_in.pos_y, i_in.pos_x};
        endcase
    end

    assign key        = {i_chip_addr, ev_word};
    assign o_pkt.key    = key;
    // Set when the key holds an even number of ones.
    assign o_pkt.parity = ~(^key);

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

endmodule

@@ hw/rtl/dvs2of7_queue.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dvs2of7_queue import dvs2of7_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_pkt,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_pkt o_pkt
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_pkt          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_pkt   = r_mem[r_rd_ptr];

    `ASSERT_CLK(a_no_push_full, !(i_push && o_full), "push into a full queue")
    `ASSERT_CLK(a_no_pop_empty, !(i_pop && !o_valid), "pop from an empty queue")

endmodule

@@ hw/rtl/dvs2of7_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dvs2of7_back import dvs2of7_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_pkt    i_pkt,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_symbol o_out
);

    // Symbol position codes; the header symbol is sent on the pop itself.
    localparam logic [3:0] IDX_ZERO_NIB = 4'd1;
    localparam logic [3:0] IDX_EOP      = 4'd10;

    logic        r_busy;
    logic [3:0]  r_idx;
    logic [31:0] r_key;
    logic        r_valid;
    logic [6:0]  r_sym;
    logic        r_last;
    logic [6:0]  r_wire;

    logic       out_free;
    logic       load;
    logic [6:0] n_sym;
    logic       n_last;

    assign out_free = ~r_valid | ~i_out_stall;
    assign o_pop    = out_free & ~r_busy & i_q_valid;

    always_comb begin
        load   = 1'b0;
        n_sym  = EOP_SYMBOL;
        n_last = 1'b0;
        if (out_free) begin
            if (r_busy) begin
                load = 1'b1;
                if (r_idx == IDX_ZERO_NIB) begin
                    n_sym = nibble_code(4'h0);
                end else if (r_idx == IDX_EOP) begin
                    n_sym  = EOP_SYMBOL;
                    n_last = 1'b1;
                end else begin
                    n_sym = nibble_code(r_key[3:0]);
                end
            end else if (i_q_valid) begin
                load  = 1'b1;
                n_sym = nibble_code({3'b000, i_pkt.parity});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
            r_wire  <= '0;
        end else begin
            if (out_free) begin
                r_valid <= load;
            end
            if (load) begin
                r_wire <= r_wire ^ n_sym;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= IDX_ZERO_NIB;
            end else if (load) begin
                r_idx <= r_idx + 4'd1;
                if (r_idx == IDX_EOP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sym  <= n_sym;
            r_last <= n_last;
        end
        if (o_pop) begin
            r_key <= i_pkt.key;
        end else if (load && r_idx != IDX_ZERO_NIB && r_idx != IDX_EOP) begin
            r_key <= {4'h0, r_key[31:4]};
        end
    end

    assign o_out_valid     = r_valid;
    assign o_out.symbol    = r_sym;
    assign o_out.wire_level = r_wire;
    assign o_out.last      = r_last;

    `ASSERT_CLK(a_pop_when_idle, !(o_pop && r_busy), "pop while a packet is in flight")
    `ASSERT_CLK(a_last_ends_packet, !(r_valid && r_last && r_busy),
        "end-of-packet shown while the sequencer is still busy")
    `ASSERT_CLK(a_idx_range, !r_busy || (r_idx >= IDX_ZERO_NIB && r_idx <= IDX_EOP),
        "symbol position out of range")
    `ASSERT_NEXT(a_wire_toggle, load, r_wire == ($past(r_wire) ^ r_sym),
        "wire levels do not follow the symbol just sent")

endmodule

@@ tb/sv/dvs_event_2of7_packet_encoder_unit_tb.sv @@
`timescale 1ns / 1ps

module dvs_event_2of7_packet_encoder_unit_tb;
    import dvs2of7_pkg::*;

    // Byte addresses of the two configuration registers on the APB port.
    localparam logic [2:0] ADDR_RES_MODE  = {REG_RES_MODE, 2'b00};
    localparam logic [2:0] ADDR_CHIP_ADDR = {REG_CHIP_ADDR, 2'b00};

    // Symbol alphabet of the link: the 2-of-7 code of each data nibble and the
    // end-of-packet marker.
    localparam logic [0:15][6:0] NIBBLE_CODE = {
        7'h11, 7'h12, 7'h14, 7'h18, 7'h21, 7'h22, 7'h24, 7'h28,
        7'h41, 7'h42, 7'h44, 7'h48, 7'h03, 7'h06, 7'h0C, 7'h09
    };
    localparam logic [6:0] END_OF_PACKET = 7'h60;
    localparam int         PACKET_LEN    = 11;

    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the long receiver hold-off used to fill the event queue.
    localparam int HOLD_CYCLES    = 80;
    // Random events per idling phase.
    localparam int PHASE_EVENTS   = 40;
    // Cycles allowed after the last expected symbol for stray extra output.
    localparam int TAIL_CYCLES    = 30;

    typedef logic [0:PACKET_LEN-1][6:0] t_packet_syms;

    // One row of the directed table. When hand_checked is set, the symbol codes
    // of the packet are typed in the row; the wire levels still follow from
    // the running XOR.
    typedef struct {
        logic [1:0]   mode;
        logic [15:0]  chip;
        t_event       ev;
        bit           hand_checked;
        t_packet_syms syms;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_event      i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_symbol     o_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dvs_event_2of7_packet_encoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // The testbench's own copy of the block's configuration and wire state.
    logic [1:0]  cfg_mode = RES_MODE_RESET;
    logic [15:0] cfg_chip = CHIP_ADDR_RESET;
    logic [6:0]  link_wires = '0;

    // Link symbols still owed by the block, oldest first.
    t_symbol exp_symbols[$];

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic recv_hold = 1'b0;
    t_symbol got_sym;
    t_symbol want_sym;

    // The directed part. It starts with the first event after reset at reset
    // configuration, then walks the coordinate extremes in each resolution
    // mode, both parity outcomes of the header, and the chip address extremes.
    // Consecutive rows share the wire state, so carry-over between packets is
    // covered too.
    t_directed_row directed_rows [0:17] = '{
        '{RES_128, 16'h0200, '{7'd0, 7'd0, 1'b0}, 1'b1,
          {7'h12, 7'h11, 7'h11, 7'h11, 7'h11, 7'h41,
           7'h11, 7'h11, 7'h14, 7'h11, 7'h60}},
        '{RES_128, 16'h0200, '{7'd127, 7'd127, 1'b1}, 1'b1,
          {7'h11, 7'h11, 7'h09, 7'h09, 7'h09, 7'h09,
           7'h11, 7'h11, 7'h14, 7'h11, 7'h60}},
        '{RES_128, 16'h0200, '{7'd127, 7'd0, 1'b0}, 1'b0, '0},
        '{RES_128, 16'h0200, '{7'd0, 7'd127, 1'b1}, 1'b0, '0},
        '{RES_128, 16'h0200, '{7'h55, 7'h2A, 1'b1}, 1'b0, '0},
        '{RES_128, 16'h0200, '{7'h2A, 7'h55, 1'b0}, 1'b0, '0},
        '{RES_64,  16'h0200, '{7'd127, 7'd127, 1'b1}, 1'b0, '0},
        '{RES_64,  16'h0200, '{7'd1, 7'd1, 1'b0}, 1'b0, '0},
        '{RES_64,  16'h0200, '{7'h40, 7'h3F, 1'b1}, 1'b0, '0},
        '{RES_32,  16'h1234, '{7'd3, 7'd3, 1'b1}, 1'b0, '0},
        '{RES_32,  16'h1234, '{7'd127, 7'd4, 1'b0}, 1'b0, '0},
        '{RES_16,  16'hFFFF, '{7'd127, 7'd127, 1'b1}, 1'b1,
          {7'h12, 7'h11, 7'h09, 7'h09, 7'h11, 7'h03,
           7'h09, 7'h09, 7'h09, 7'h09, 7'h60}},
        '{RES_16,  16'hFFFF, '{7'd7, 7'd7, 1'b0}, 1'b0, '0},
        '{RES_16,  16'hFFFF, '{7'd8, 7'h40, 1'b1}, 1'b0, '0},
        '{RES_128, 16'h0000, '{7'd0, 7'd0, 1'b0}, 1'b1,
          {7'h11, 7'h11, 7'h11, 7'h11, 7'h11, 7'h41,
           7'h11, 7'h11, 7'h11, 7'h11, 7'h60}},
        '{RES_128, 16'h0000, '{7'h7F, 7'd0, 1'b1}, 1'b0, '0},
        '{RES_128, 16'hAAAA, '{7'h12, 7'h34, 1'b0}, 1'b0, '0},
        '{RES_128, 16'h5555, '{7'h21, 7'h43, 1'b1}, 1'b0, '0}
    };

    // 4 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Every mismatch goes through here: one line each, and a count.
    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Appends one packet to the expected symbols, toggling the wires symbol by
    // symbol exactly as the link does.
    task automatic push_packet(t_packet_syms syms);
        t_symbol s;
        for (int k = 0; k < PACKET_LEN; k++) begin
            link_wires   = link_wires ^ syms[k];
            s.symbol     = syms[k];
            s.wire_level = link_wires;
            s.last       = (k == PACKET_LEN - 1);
            exp_symbols.push_back(s);
        end
    endtask

    // Builds the routing key of an event under the current configuration and
    // predicts its eleven link symbols.
    task automatic predict_packet(t_event ev);
        logic [15:0]  word;
        logic [31:0]  route_key;
        logic         parity;
        t_packet_syms syms;
        word = {1'b1, ev.polarity, 14'd0};
        case (cfg_mode)
            RES_64:  word[11:0] = {ev.pos_y[6:1], ev.pos_x[6:1]};
            RES_32:  word[9:0]  = {ev.pos_y[6:2], ev.pos_x[6:2]};
            RES_16:  word[7:0]  = {ev.pos_y[6:3], ev.pos_x[6:3]};
            default: word[13:0] = {ev.pos_y, ev.pos_x};
        endcase
        route_key = {cfg_chip, word};
        // Odd parity over the routing key: set when the key has an even count.
        parity = ~^route_key;
        syms[0] = NIBBLE_CODE[{3'b000, parity}];
        syms[1] = NIBBLE_CODE[0];
        for (int k = 0; k < 8; k++) begin
            syms[2 + k] = NIBBLE_CODE[route_key[4*k +: 4]];
        end
        syms[PACKET_LEN - 1] = END_OF_PACKET;
        push_packet(syms);
    endtask

    // Offers one event and returns at the edge where it is taken. Valid stays
    // high on return; the caller's next drive decides what happens to it in
    // the same time step.
    task automatic offer_event(t_event ev);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= ev;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every expected symbol has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (exp_symbols.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One APB transaction: setup cycle, then access until pready. The bus is
    // left selected so that transactions chain without a second drive of psel
    // in one time step; apb_release ends a chain.
    task automatic apb_xfer(logic is_write, logic [2:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        rdata = prdata;
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reads both registers back and compares them with the expected settings.
    task automatic check_registers(logic [1:0] mode, logic [15:0] chip);
        logic [31:0] rd;
        apb_xfer(1'b0, ADDR_RES_MODE, '0, rd);
        if (rd[1:0] !== mode) begin
            report_mismatch($sformatf("resolution_mode reads %0h, want %0h", rd[1:0], mode));
        end
        apb_xfer(1'b0, ADDR_CHIP_ADDR, '0, rd);
        if (rd[15:0] !== chip) begin
            report_mismatch($sformatf("chip_address reads %h, want %h", rd[15:0], chip));
        end
    endtask

    // Changes the configuration once the block has gone idle, then reads it back.
    task automatic set_config(logic [1:0] mode, logic [15:0] chip);
        logic [31:0] rd;
        wait_drained();
        apb_xfer(1'b1, ADDR_RES_MODE, {30'd0, mode}, rd);
        apb_xfer(1'b1, ADDR_CHIP_ADDR, {16'd0, chip}, rd);
        check_registers(mode, chip);
        apb_release();
        cfg_mode = mode;
        cfg_chip = chip;
    endtask

    // Random event: mostly uniform coordinates, now and then a corner value.
    function automatic t_event random_event();
        t_event ev;
        ev.pos_x    = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 7'd127 : 7'd0)
                                               : 7'($urandom_range(127));
        ev.pos_y    = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 7'd127 : 7'd0)
                                               : 7'($urandom_range(127));
        ev.polarity = 1'($urandom_range(1));
        return ev;
    endfunction

    // Receiver side: random stalls at the phase's rate, plus the long hold-off.
    always @(posedge i_clk) begin
        i_out_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // Output checker: every symbol transaction is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_sym = o_out;
            if (exp_symbols.size() == 0) begin
                report_mismatch($sformatf("unexpected symbol %h (wires %h, last %b)",
                                          got_sym.symbol, got_sym.wire_level, got_sym.last));
            end else begin
                want_sym = exp_symbols.pop_front();
                if (got_sym.symbol !== want_sym.symbol) begin
                    report_mismatch($sformatf("symbol %h, want %h",
                                              got_sym.symbol, want_sym.symbol));
                end
                if (got_sym.wire_level !== want_sym.wire_level) begin
                    report_mismatch($sformatf("wire_level %h, want %h",
                                              got_sym.wire_level, want_sym.wire_level));
                end
                if (got_sym.last !== want_sym.last) begin
                    report_mismatch($sformatf("last %b, want %b",
                                              got_sym.last, want_sym.last));
                end
            end
        end
    end

    // Watchdog: any transaction on either channel or the APB port resets it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("dvs_event_2of7_packet_encoder_unit_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial begin
        logic [1:0]  phase_mode;
        logic [15:0] phase_chip;
        t_event      ev;

        // Synchronous reset is held low first, then released.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers must come up at their reset values.
        check_registers(RES_MODE_RESET, CHIP_ADDR_RESET);
        apb_release();

        // Directed table. A row whose configuration differs from the current
        // one drains the block first and reprograms it, which also makes the
        // sender pause until every outstanding symbol has arrived.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].mode != cfg_mode || directed_rows[i].chip != cfg_chip) begin
                set_config(directed_rows[i].mode, directed_rows[i].chip);
            end
            offer_event(directed_rows[i].ev);
            if (directed_rows[i].hand_checked) begin
                push_packet(directed_rows[i].syms);
            end else begin
                predict_packet(directed_rows[i].ev);
            end
        end

        // Random phases, each under its own configuration and an idling pattern.
        // The first and last use the configuration extremes.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    phase_mode = RES_128;
                    phase_chip = 16'hFFFF;
                end
                4: begin
                    phase_mode = RES_16;
                    phase_chip = 16'h0000;
                end
                default: begin
                    phase_mode = 2'($urandom_range(3));
                    phase_chip = 16'($urandom_range(16'hFFFF));
                end
            endcase
            set_config(phase_mode, phase_chip);

            case (phase)
                1: begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 88;
                end
                3: begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            // In the last phase the receiver holds off for a long stretch while
            // events keep coming, so the queue fills and the input stalls.
            if (phase == 4) begin
                fork
                    begin
                        recv_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        recv_hold <= 1'b0;
                    end
                join_none
            end

            for (int n = 0; n < PHASE_EVENTS; n++) begin
                ev = random_event();
                offer_event(ev);
                predict_packet(ev);
            end
        end

        // Drain, then give the block time to show any stray extra symbol.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (exp_symbols.size() != 0) begin
            report_mismatch($sformatf("%0d expected symbols never arrived", exp_symbols.size()));
        end

        if (mismatch_count == 0) begin
            $display("dvs_event_2of7_packet_encoder_unit_tb: done, clean");
        end else begin
            $display("dvs_event_2of7_packet_encoder_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ dvs_event_2of7_packet_encoder_unit.f @@
+incdir+hw/rtl
hw/rtl/dvs2of7_pkg.sv
hw/rtl/dvs2of7_front.sv
hw/rtl/dvs2of7_queue.sv
hw/rtl/dvs2of7_back.sv
hw/rtl/dvs_event_2of7_packet_encoder_unit.sv
tb/sv/dvs_event_2of7_packet_encoder_unit_tb.sv
